// ===== design/cdh_pkg.sv =====
// Package for the code point dual hash: item types, state type and mixing constants.
`timescale 1ns / 1ps

package cdh_pkg;

   localparam int unsigned CP_W    = 21;
   localparam int unsigned LEN_W   = 31;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned PROD_W  = 32;

   localparam logic [LEN_W-1:0]  COUNT_MAX  = {LEN_W{1'b1}};
   localparam logic [WORD_W-1:0] WORD1_SEED = 64'd60899;

   localparam logic [WORD_W-1:0] MUL_W0_PH0 = 64'd60869;
   localparam logic [WORD_W-1:0] MUL_W1_PH1 = 64'd53087;
   localparam logic [WORD_W-1:0] MUL_W1_PH2 = 64'd73063;
   localparam logic [WORD_W-1:0] MUL_W0_PH3 = 64'd73019;

   localparam logic [PROD_W-1:0] MUL_CP_PH0 = 32'd5059;
   localparam logic [PROD_W-1:0] MUL_CP_PH1 = 32'd43063;
   localparam logic [PROD_W-1:0] MUL_CP_PH2 = 32'd53089;
   localparam logic [PROD_W-1:0] MUL_CP_PH3 = 32'd23057;

   localparam logic [12:0] MUL_LOW9 = 13'd11;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2,
      PHASE_3 = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic             first_char;
      logic             last_char;
      logic [LEN_W-1:0] byte_length;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] hash_word0;
      logic signed [WORD_W-1:0] hash_word1;
      logic [LEN_W-1:0]         char_count;
   } rsp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [LEN_W-1:0]  chars_seen;
      phase_type         phase;
   } hash_state_type;

endpackage

// ===== design/cdh_if.sv =====
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps

interface cdh_req_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        first_char;
   logic        last_char;
   logic [30:0] byte_length;

   modport source (output valid, output code_point, output first_char,
                   output last_char, output byte_length, input ready);
   modport sink   (input valid, input code_point, input first_char,
                   input last_char, input byte_length, output ready);
endinterface

interface cdh_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] hash_word0;
   logic signed [63:0] hash_word1;
   logic [30:0]        char_count;

   modport source (output valid, output hash_word0, output hash_word1,
                   output char_count, input ready);
   modport sink   (input valid, input hash_word0, input hash_word1,
                   input char_count, output ready);
endinterface

// ===== design/codepoint_dual_hash_core.sv =====
// Top level of the code point dual hash: input register, state update, result register.
//
//   channel  dir  payload                                         handshake
//   req      in   code_point, first_char, last_char, byte_length  valid/ready
//   rsp      out  hash_word0, hash_word1, char_count              valid/ready
//
// An accepted item is held in the input register, then updates the hash state;
// its result, if any, is loaded into the result register by the same update.
// One item per cycle is sustained while no result waits on rsp; the state update loop is one register deep.
// Synchronous reset clears the hash state and all valid flags.
// A result waiting on rsp stalls the input register only; req stays ready while
// the input register is empty or draining.
`timescale 1ns / 1ps

module codepoint_dual_hash_core
   import cdh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   cdh_req_if.sink   req_chan,
   cdh_rsp_if.source rsp_chan
);

   logic           in_valid_ff;
   req_item_type   in_item_ff;
   hash_state_type state_ff;
   hash_state_type state_in;
   logic           out_valid_ff;
   rsp_item_type   out_item_ff;
   rsp_item_type   mix_rsp;
   logic           mix_fire;
   logic           advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.code_point  <= req_chan.code_point;
         in_item_ff.first_char  <= req_chan.first_char;
         in_item_ff.last_char   <= req_chan.last_char;
         in_item_ff.byte_length <= req_chan.byte_length;
      end
   end

   cdh_mix u_mix (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .rsp_fire  (mix_fire),
      .rsp_item  (mix_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mix_fire;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && mix_fire) begin
         out_item_ff <= mix_rsp;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hash_word0 = out_item_ff.hash_word0;
   assign rsp_chan.hash_word1 = out_item_ff.hash_word1;
   assign rsp_chan.char_count = out_item_ff.char_count;

endmodule

// ===== design/cdh_mix.sv =====
// Combinational mixing step: next hash state and optional result for one item.
`timescale 1ns / 1ps

module cdh_mix
   import cdh_pkg::*;
(
   input  hash_state_type state_cur,
   input  req_item_type   item,
   output hash_state_type state_nxt,
   output logic           rsp_fire,
   output rsp_item_type   rsp_item
);

   hash_state_type      base;
   logic [LEN_W-1:0]    count_nxt;
   logic [PROD_W-1:0]   cp_ext;
   logic [PROD_W-1:0]   prod;
   logic [12:0]         low9_mul;
   logic [WORD_W-1:0]   word_mul;
   logic [WORD_W-1:0]   term;
   logic                empty_str;

   assign empty_str = item.first_char && (item.byte_length == '0);
   assign cp_ext    = PROD_W'(item.code_point);
   assign low9_mul  = 13'(base.word1[8:0]) * MUL_LOW9;

   always_comb begin
      base = state_cur;
      if (item.first_char) begin
         base.word0      = WORD_W'(item.byte_length);
         base.word1      = WORD1_SEED;
         base.chars_seen = '0;
         base.phase      = PHASE_0;
      end
   end

   assign count_nxt = (base.chars_seen == COUNT_MAX) ? base.chars_seen
                                                     : base.chars_seen + 1'b1;

   always_comb begin
      unique case (base.phase)
         PHASE_0: begin
            prod     = cp_ext * MUL_CP_PH0;
            word_mul = base.word0 * MUL_W0_PH0;
            term     = WORD_W'(prod) + WORD_W'(base.word1[7:0]);
         end
         PHASE_1: begin
            prod     = cp_ext * MUL_CP_PH1 + PROD_W'(base.chars_seen);
            word_mul = base.word1 * MUL_W1_PH1;
            term     = WORD_W'(prod) + WORD_W'(base.word0[7:0]);
         end
         PHASE_2: begin
            prod     = cp_ext * MUL_CP_PH2;
            word_mul = base.word1 * MUL_W1_PH2;
            term     = WORD_W'(prod) + WORD_W'(base.word0[7:0]);
         end
         default: begin
            prod     = cp_ext * MUL_CP_PH3;
            word_mul = base.word0 * MUL_W0_PH3;
            term     = WORD_W'(prod) + WORD_W'(low9_mul);
         end
      endcase
   end

   always_comb begin
      state_nxt            = base;
      state_nxt.chars_seen = count_nxt;
      state_nxt.phase      = phase_type'(base.phase + 2'd1);
      unique case (base.phase)
         PHASE_0: begin
            if (!item.last_char) begin
               state_nxt.word0 = word_mul ^ term;
            end
         end
         PHASE_1, PHASE_2: begin
            state_nxt.word1 = word_mul ^ term;
         end
         default: begin
            state_nxt.word0 = word_mul ^ term;
         end
      endcase
      if (empty_str) begin
         state_nxt = '0;
      end
   end

   always_comb begin
      rsp_fire            = empty_str || item.last_char;
      rsp_item.hash_word0 = $signed(state_nxt.word0);
      rsp_item.hash_word1 = $signed(state_nxt.word1);
      rsp_item.char_count = state_nxt.chars_seen;
   end

endmodule

// ===== verif/codepoint_dual_hash_core_tb.sv =====
// Self-checking testbench for codepoint_dual_hash_core: random strings, stalls, scoreboard.
`timescale 1ns / 1ps

module codepoint_dual_hash_core_tb;
   import cdh_pkg::*;

   localparam logic [CP_W-1:0]  CP_TOP  = 21'h10FFFF;
   localparam logic [LEN_W-1:0] LEN_TOP = {LEN_W{1'b1}};

   class hash_scoreboard;
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [LEN_W-1:0]  chars_seen;
      phase_type         phase;
      rsp_item_type      expected_digests[$];
      int unsigned       failures;
      int unsigned       digests_checked;

      function new();
         word0 = '0;
         word1 = '0;
         chars_seen = '0;
         phase = PHASE_0;
         failures = 0;
         digests_checked = 0;
      endfunction

      function int unsigned pending();
         return expected_digests.size();
      endfunction

      // Runs one accepted item through the hash and queues the digest it causes.
      function void note_char(req_item_type item);
         logic [PROD_W-1:0] cp32;
         logic [PROD_W-1:0] prod;
         logic [LEN_W-1:0]  count_before;
         rsp_item_type      digest;
         cp32 = {11'd0, item.code_point};
         if (item.first_char) begin
            chars_seen = '0;
            phase = PHASE_0;
            if (item.byte_length == '0) begin
               word0 = '0;
               word1 = '0;
               digest = '0;
               expected_digests.push_back(digest);
               return;
            end
            word0 = {33'd0, item.byte_length};
            word1 = WORD1_SEED;
         end
         count_before = chars_seen;
         if (chars_seen != COUNT_MAX)
            chars_seen = chars_seen + 1'b1;
         case (phase)
            PHASE_0: begin
               // a last character here is counted only
               if (!item.last_char) begin
                  prod = cp32 * MUL_CP_PH0;
                  word0 = (word0 * MUL_W0_PH0) ^ ({32'd0, prod} + {56'd0, word1[7:0]});
               end
            end
            PHASE_1: begin
               prod = cp32 * MUL_CP_PH1 + {1'b0, count_before};
               word1 = (word1 * MUL_W1_PH1) ^ ({32'd0, prod} + {56'd0, word0[7:0]});
            end
            PHASE_2: begin
               prod = cp32 * MUL_CP_PH2;
               word1 = (word1 * MUL_W1_PH2) ^ ({32'd0, prod} + {56'd0, word0[7:0]});
            end
            default: begin
               prod = cp32 * MUL_CP_PH3;
               word0 = (word0 * MUL_W0_PH3) ^
                       ({32'd0, prod} + {51'd0, MUL_LOW9} * {55'd0, word1[8:0]});
            end
         endcase
         phase = phase_type'(phase + 2'd1);
         if (item.last_char) begin
            digest.hash_word0 = word0;
            digest.hash_word1 = word1;
            digest.char_count = chars_seen;
            expected_digests.push_back(digest);
         end
      endfunction

      function void check_digest(rsp_item_type got);
         rsp_item_type want;
         if (expected_digests.size() == 0) begin
            $display("%0t: unexpected digest w0=%h w1=%h count=%0d",
                     $time, got.hash_word0, got.hash_word1, got.char_count);
            failures++;
            return;
         end
         want = expected_digests.pop_front();
         digests_checked++;
         if (got.hash_word0 !== want.hash_word0) begin
            $display("%0t: hash_word0 expected %h, actual %h",
                     $time, want.hash_word0, got.hash_word0);
            failures++;
         end
         if (got.hash_word1 !== want.hash_word1) begin
            $display("%0t: hash_word1 expected %h, actual %h",
                     $time, want.hash_word1, got.hash_word1);
            failures++;
         end
         if (got.char_count !== want.char_count) begin
            $display("%0t: char_count expected %0d, actual %0d",
                     $time, want.char_count, got.char_count);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   cdh_req_if req_chan ();
   cdh_rsp_if rsp_chan ();

   codepoint_dual_hash_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hash_scoreboard sb;

   bit          send_idle_on;
   bit          recv_idle_on;
   bit          long_hold_req;
   int unsigned recv_stall_left;
   int unsigned hold_left;
   int unsigned chars_sent;
   int unsigned strings_sent;
   int unsigned empties_sent;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[codepoint_dual_hash_core] ERROR");
      $finish;
   end

   // receiver: random stall bursts plus one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (recv_stall_left != 0) begin
         recv_stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
         recv_stall_left = $urandom_range(0, 17);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_item_type item;
      rsp_item_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            item.code_point  = req_chan.code_point;
            item.first_char  = req_chan.first_char;
            item.last_char   = req_chan.last_char;
            item.byte_length = req_chan.byte_length;
            sb.note_char(item);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hash_word0 = rsp_chan.hash_word0;
            got.hash_word1 = rsp_chan.hash_word1;
            got.char_count = rsp_chan.char_count;
            sb.check_digest(got);
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_char(input logic [CP_W-1:0] cp, input logic first,
                            input logic last, input logic [LEN_W-1:0] blen);
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.code_point  <= cp;
      req_chan.first_char  <= first;
      req_chan.last_char   <= last;
      req_chan.byte_length <= blen;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      chars_sent++;
   endtask

   function automatic logic [CP_W-1:0] pick_code_point();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CP_TOP;
         2, 3:    return CP_W'($urandom_range(0, 127));
         default: return CP_W'($urandom_range(0, 1114111));
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_byte_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LEN_TOP;
         2, 3, 4: return LEN_W'($urandom_range(1, 64));
         default: return LEN_W'($urandom_range(1, 32'h7FFF_FFFF));
      endcase
   endfunction

   task automatic send_string(input int unsigned n_chars, input logic [LEN_W-1:0] blen,
                              input bit with_last);
      for (int unsigned i = 0; i < n_chars; i++)
         send_char(pick_code_point(), i == 0, with_last && (i == n_chars - 1),
                   (i == 0) ? blen : LEN_W'($urandom));
      strings_sent++;
      if (blen == '0)
         empties_sent++;
   endtask

   task automatic send_random_item();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
         send_string(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(1, 6),
                     pick_byte_length(), 1'b1);
      end else if (pick == 16) begin
         repeat ($urandom_range(1, 4))
            send_char(pick_code_point(), 1'b0, 1'b0, LEN_W'($urandom));
      end else if (pick == 17) begin
         send_string($urandom_range(1, 5), pick_byte_length(), 1'b0);
      end else if (pick == 18) begin
         send_char(pick_code_point(), 1'b1, 1'($urandom), '0);
         empties_sent++;
      end else begin
         send_char(pick_code_point(), 1'b0, 1'b1, LEN_W'($urandom));
      end
   endtask

   initial begin
      sb = new();
      send_idle_on    = 1'b0;
      recv_idle_on    = 1'b0;
      long_hold_req   = 1'b0;
      recv_stall_left = 0;
      hold_left       = 0;
      chars_sent      = 0;
      strings_sent    = 0;
      empties_sent    = 0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.code_point  = '0;
      req_chan.first_char  = 1'b0;
      req_chan.last_char   = 1'b0;
      req_chan.byte_length = '0;
      rsp_chan.ready       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // characters before any first item mix into the reset state
      send_char('0, 1'b0, 1'b0, '0);
      send_char(CP_TOP, 1'b0, 1'b0, LEN_TOP);
      send_char(21'd1, 1'b0, 1'b1, '0);
      // empty strings, with and without last
      send_char(CP_TOP, 1'b1, 1'b0, '0);
      send_char(21'h1234, 1'b1, 1'b1, '0);
      empties_sent += 2;
      // continue after an empty string, last at phase 0
      send_char(21'd65, 1'b0, 1'b1, '0);
      send_char(CP_TOP, 1'b1, 1'b1, LEN_TOP);
      send_char('0, 1'b1, 1'b0, 31'd1);
      send_char(CP_TOP, 1'b0, 1'b1, '0);
      for (int unsigned n = 3; n <= 5; n++)
         send_string(n, LEN_W'(n * 3), 1'b1);
      // state kept after a result
      send_char(CP_TOP, 1'b0, 1'b0, '0);
      send_char(21'd7, 1'b0, 1'b1, '0);

      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      while (chars_sent < 700)
         send_random_item();

      // long receiver hold-off while short strings keep coming
      send_idle_on  = 1'b0;
      long_hold_req = 1'b1;
      repeat (40)
         send_string($urandom_range(1, 2), pick_byte_length(), 1'b1);

      while (chars_sent < 1500) begin
         send_idle_on = $urandom_range(0, 3) != 0;
         recv_idle_on = $urandom_range(0, 3) != 0;
         repeat (12)
            send_random_item();
      end

      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      while (chars_sent < 1825)
         send_random_item();
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d characters in %0d strings (%0d empty).",
               chars_sent, strings_sent, empties_sent);
      $display("Checked %0d digests across idle, stall and hold-off phases.",
               sb.digests_checked);
      if (sb.failures == 0)
         $display("[codepoint_dual_hash_core] OK");
      else
         $display("[codepoint_dual_hash_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/cdh_pkg.sv
design/cdh_if.sv
design/cdh_mix.sv
design/codepoint_dual_hash_core.sv
verif/codepoint_dual_hash_core_tb.sv
